// File: rtl/connect_backoff_blocker_core_defines.svh
`ifndef CONNECT_BACKOFF_BLOCKER_CORE_DEFINES_SVH
`define CONNECT_BACKOFF_BLOCKER_CORE_DEFINES_SVH

// Property that must hold at every rising edge outside reset.
`define CBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CBB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `CBB_ASSERT(lbl, clk, rstn, !(cond), msg)

`endif

// File: rtl/cbb_pkg.sv
package cbb_pkg;

  localparam int DEF_MAX_EXPONENT = 10;
  localparam int DEF_COUNT_BITS   = 16;
  localparam int TABLE_TOP        = 16;

  localparam int BASE_W   = 20;
  localparam int FACTOR_W = 19;
  localparam int PROD_W   = BASE_W + FACTOR_W;
  localparam int MAG_W    = 16;
  localparam int TICK_W   = 28;
  localparam int EXP_W    = 5;

  localparam logic [BASE_W-1:0] BASE_TICKS_RESET = 20'd1000;

  // jitter divide by 5 runs one byte a step
  localparam int DIV_STEPS = 5;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_SUCCESS = 3'd1,
    ACT_FAILURE = 3'd2,
    ACT_OFFLINE = 3'd3,
    ACT_ONLINE  = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] random_sample;
  } cbb_in_t;

  typedef struct packed {
    logic        blocked;
    logic [15:0] fail_count;
    logic        ignored;
    logic [27:0] backoff_loaded;
  } cbb_out_t;

  typedef struct packed {
    logic capture;
    logic bump;
    logic mul_base;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic apply;
  } cbb_cmd_t;

  typedef struct packed {
    logic start_fail;
  } cbb_status_t;

  // round(1.6^e * 256)
  function automatic logic [FACTOR_W-1:0] factor_q8(input logic [EXP_W-1:0] e);
    logic [FACTOR_W-1:0] f;
    case (e)
      5'd0:    f = 19'd256;
      5'd1:    f = 19'd410;
      5'd2:    f = 19'd655;
      5'd3:    f = 19'd1049;
      5'd4:    f = 19'd1678;
      5'd5:    f = 19'd2684;
      5'd6:    f = 19'd4295;
      5'd7:    f = 19'd6872;
      5'd8:    f = 19'd10995;
      5'd9:    f = 19'd17592;
      5'd10:   f = 19'd28147;
      5'd11:   f = 19'd45036;
      5'd12:   f = 19'd72058;
      5'd13:   f = 19'd115292;
      5'd14:   f = 19'd184467;
      5'd15:   f = 19'd295148;
      default: f = 19'd472237;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/cbb_ctrl.sv
`include "connect_backoff_blocker_core_defines.svh"

module cbb_ctrl import cbb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cbb_status_t status_i,
  output cbb_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_BASE,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_FINISH
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] step_q, step_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.capture = in_valid_i && in_ready_o;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (status_i.start_fail) begin
          cmd_o.bump = 1'b1;
          state_d    = S_MUL_BASE;
        end else if (out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_MUL_BASE: begin
        cmd_o.mul_base = 1'b1;
        state_d        = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        step_d       = '0;
        state_d      = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd_o.apply = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.apply) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CBB_ASSERT(a_apply_slot_free, clk_i, rst_ni, cmd_o.apply |-> out_free, "result overwrites a pending transfer")
  `CBB_ASSERT(a_one_item, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "second item taken while busy")
  `CBB_ASSERT(a_finish_after_div, clk_i, rst_ni, (state_q == S_FINISH) |-> ($past(state_q) == S_DIV || $past(state_q) == S_FINISH), "finish reached without divide")

endmodule

// File: rtl/cbb_datapath.sv
`include "connect_backoff_blocker_core_defines.svh"

module cbb_datapath import cbb_pkg::*; #(
  parameter int MAX_EXPONENT = DEF_MAX_EXPONENT,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BASE_W-1:0] cfg_wdata_i,
  input  cbb_in_t           in_data_i,
  input  cbb_cmd_t          cmd_i,
  output cbb_status_t       status_o,
  output cbb_out_t          out_data_o
);

  localparam int EXP_LIMIT = (MAX_EXPONENT < TABLE_TOP) ? MAX_EXPONENT : TABLE_TOP;
  localparam int LO_W      = 20 + MAG_W;
  localparam int HI_W      = (PROD_W - 20) + MAG_W;
  localparam int ACC_W     = PROD_W + MAG_W;
  localparam int DV_W      = ACC_W - 15;
  localparam int TOT_W     = DV_W + 1;
  localparam int RECIP_W   = 25;

  // state and config
  logic [BASE_W-1:0]     base_q;
  logic [COUNT_BITS-1:0] fail_q, fail_d;
  logic [TICK_W-1:0]     rem_q, rem_d;
  logic                  active_q, active_d;
  logic                  offline_q, offline_d;

  // working registers
  logic [2:0]        action_q;
  logic [15:0]       sample_q;
  logic [PROD_W-1:0] prod_q;
  logic [LO_W-1:0]   lo_q;
  logic [DV_W-1:0]   dv_q, dv_d;
  logic [2:0]        rdiv_q, rdiv_d;
  cbb_out_t          out_q, out_d;

  logic                blocked;
  logic                up;
  logic [MAG_W-1:0]    mag;
  logic [31:0]         count_ext;
  logic [EXP_W-1:0]    expo;
  logic [PROD_W-1:0]   prod_d;
  logic [LO_W-1:0]     lo_d;
  logic [HI_W-1:0]     hi_prod;
  logic [ACC_W-1:0]    acc;
  logic [10:0]         div_val;
  logic [RECIP_W-1:0]  recip;
  logic [7:0]          qdig;
  logic [10:0]         rem_full;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    rounded;
  logic [TOT_W-9:0]    ticks_wide;
  logic [TICK_W-1:0]   ticks;
  logic [TICK_W-1:0]   rem_dec;
  logic                ign;
  logic [TICK_W-1:0]   loaded;

  assign blocked             = active_q || offline_q;
  assign status_o.start_fail = (action_q == ACT_FAILURE) && !blocked;
  assign out_data_o          = out_q;

  // exponent and base product
  assign count_ext = 32'(fail_q);
  assign expo      = (count_ext > 32'(EXP_LIMIT)) ? EXP_W'(EXP_LIMIT) : count_ext[EXP_W-1:0];
  assign prod_d    = PROD_W'(base_q) * PROD_W'(factor_q8(expo));

  // jitter magnitude and direction
  assign up  = sample_q[15];
  assign mag = up ? {1'b0, sample_q[14:0]} : (16'h8000 - sample_q);

  // prod * mag in two partial products, then drop the 2^15 part of /163840
  assign lo_d    = LO_W'(prod_q[19:0]) * LO_W'(mag);
  assign hi_prod = HI_W'(prod_q[PROD_W-1:20]) * HI_W'(mag);
  assign acc     = ACC_W'(lo_q) + (ACC_W'(hi_prod) << 20);

  // divide by 5, one byte per step; 13108/65536 is exact for values below 1280
  assign div_val  = {rdiv_q, dv_q[DV_W-1:DV_W-8]};
  assign recip    = RECIP_W'(div_val) * RECIP_W'(14'd13108);
  assign qdig     = recip[23:16];
  assign rem_full = div_val - (11'(qdig) * 11'd5);

  always_comb begin
    dv_d   = dv_q;
    rdiv_d = rdiv_q;
    if (cmd_i.mul_hi) begin
      dv_d   = acc[ACC_W-1:15];
      rdiv_d = '0;
    end else if (cmd_i.div_step) begin
      dv_d   = {dv_q[DV_W-9:0], qdig};
      rdiv_d = rem_full[2:0];
    end
  end

  // add or subtract jitter, round half up, clamp
  assign total      = up ? (TOT_W'(prod_q) + TOT_W'(dv_q)) : (TOT_W'(prod_q) - TOT_W'(dv_q));
  assign rounded    = total + TOT_W'(128);
  assign ticks_wide = rounded[TOT_W-1:8];
  always_comb begin
    if (ticks_wide == '0) begin
      ticks = TICK_W'(1);
    end else if (|ticks_wide[TOT_W-9:TICK_W]) begin
      ticks = '1;
    end else begin
      ticks = ticks_wide[TICK_W-1:0];
    end
  end

  assign rem_dec = (rem_q != '0) ? (rem_q - 1'b1) : '0;

  always_comb begin
    fail_d    = fail_q;
    rem_d     = rem_q;
    active_d  = active_q;
    offline_d = offline_q;
    ign       = 1'b0;
    loaded    = '0;
    if (cmd_i.bump && (fail_q != '1)) begin
      fail_d = fail_q + 1'b1;
    end
    if (cmd_i.apply) begin
      case (action_q)
        ACT_TICK: begin
          if (active_q) begin
            rem_d = rem_dec;
            if (rem_dec == '0) begin
              active_d = 1'b0;
            end
          end
        end
        ACT_SUCCESS: begin
          if (blocked) begin
            ign = 1'b1;
          end else begin
            fail_d = '0;
          end
        end
        ACT_FAILURE: begin
          if (blocked) begin
            ign = 1'b1;
          end else begin
            rem_d    = ticks;
            active_d = 1'b1;
            loaded   = ticks;
          end
        end
        ACT_OFFLINE: begin
          active_d  = 1'b0;
          rem_d     = '0;
          offline_d = 1'b1;
        end
        ACT_ONLINE: begin
          active_d  = 1'b0;
          rem_d     = '0;
          offline_d = 1'b0;
          fail_d    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_d.blocked        = active_d || offline_d;
    out_d.fail_count     = 16'(32'(fail_d));
    out_d.ignored        = ign;
    out_d.backoff_loaded = loaded;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= BASE_TICKS_RESET;
      fail_q    <= '0;
      rem_q     <= '0;
      active_q  <= 1'b0;
      offline_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end
      fail_q    <= fail_d;
      rem_q     <= rem_d;
      active_q  <= active_d;
      offline_q <= offline_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= in_data_i.action;
      sample_q <= in_data_i.random_sample;
    end
    if (cmd_i.mul_base) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_lo) begin
      lo_q <= lo_d;
    end
    dv_q   <= dv_d;
    rdiv_q <= rdiv_d;
    if (cmd_i.apply) begin
      out_q <= out_d;
    end
  end

  `CBB_ASSERT(a_active_has_ticks, clk_i, rst_ni, active_q == (rem_q != '0), "countdown flag and remaining ticks disagree")
  `CBB_ASSERT_NEVER(a_hold_exclusive, clk_i, rst_ni, active_q && offline_q, "countdown running during offline hold")
  `CBB_ASSERT(a_load_nonzero, clk_i, rst_ni, (cmd_i.apply && status_o.start_fail) |=> (out_q.backoff_loaded != '0), "failure loaded zero ticks")

endmodule

// File: rtl/connect_backoff_blocker_core.sv
// Connection retry blocker with exponential backoff and jitter.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one event per
// transfer: tick, success, failure, offline or online, with a 16-bit random
// sample for jitter. Output channel (out_valid_o/out_ready_i, out_data_o)
// returns one result per event: blocked, fail count, ignored flag and the
// backoff loaded by a failure.
// The user must write base_ticks through cfg_we_i/cfg_wdata_i only while
// the block is idle; the block itself does not enforce this. Items are
// handled one at a time. An event that loads no backoff has its result
// registered in the evaluate step; the next event is taken once back in idle.
// A failure that loads a backoff runs an evaluate step, three multiply
// steps (base times factor, then the jitter product in two partial
// products), five byte steps of the divide by five and a finish step.
// The output register frees the core: the next event is taken while a result
// waits, but that event is not finished until the waiting result is taken,
// and receiver stall then delays it.
// Reset clears the fail count, countdown and offline hold, sets base_ticks
// to 1000 and empties the output register.
module connect_backoff_blocker_core import cbb_pkg::*; #(
  parameter int MAX_EXPONENT = DEF_MAX_EXPONENT,
  parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BASE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cbb_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cbb_out_t          out_data_o
);

  cbb_cmd_t    cmd;
  cbb_status_t status;

  cbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbb_datapath #(
    .MAX_EXPONENT (MAX_EXPONENT),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/connect_backoff_blocker_core_test.sv
module connect_backoff_blocker_core_test import cbb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_EXP        = 10;
  localparam int          CYCLE_LIMIT    = 3_000_000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          PHASE_ITEMS    = 180;
  localparam int          RUN_FAILURES   = 20;
  localparam logic [2:0]  ACT_SPARE_LO   = 3'd5;
  localparam logic [2:0]  ACT_SPARE_MID  = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI   = 3'd7;
  localparam logic [15:0] JITTER_NONE    = 16'd32768;
  localparam logic [15:0] JITTER_LOW     = 16'd0;
  localparam logic [15:0] JITTER_HIGH    = 16'hFFFF;
  localparam logic [15:0] COUNT_TOP      = 16'hFFFF;
  localparam logic [27:0] TICKS_TOP      = 28'hFFFFFFF;

  // 1.6^e in Q11.8, rounded
  localparam longint unsigned GROWTH_Q8 [0:16] = '{
    256, 410, 655, 1049, 1678, 2684, 4295, 6872, 10995,
    17592, 28147, 45036, 72058, 115292, 184467, 295148, 472237
  };

  typedef struct {
    bit                is_cfg;
    logic [BASE_W-1:0] base;
    cbb_in_t           ev;
    bit                typed;
    cbb_out_t          want;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BASE_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  cbb_in_t           in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  cbb_out_t          out_data_o;

  // predictor state
  logic [BASE_W-1:0] base_ticks_q;
  logic [15:0]       fails_q;
  logic [27:0]       remain_q;
  bit                counting_q;
  bit                offline_q;

  cbb_out_t          pending_results [$];
  cbb_out_t          head;
  int unsigned       mismatches;
  int unsigned       cycle_count;
  bit                calm;
  bit                hold_req;

  connect_backoff_blocker_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [27:0] backoff_ticks(logic [15:0] count, logic [15:0] smp);
    longint unsigned e, prod, mag, jit, total, ticks;
    bit up;
    e = (count > MAX_EXP) ? MAX_EXP : count;
    prod = longint'(base_ticks_q) * GROWTH_Q8[e];
    up = (smp >= JITTER_NONE);
    mag = up ? (smp - JITTER_NONE) : (JITTER_NONE - smp);
    jit = (prod * mag) / 163840;
    total = up ? prod + jit : prod - jit;
    ticks = (total + 128) >> 8;
    if (ticks < 1) ticks = 1;
    if (ticks > TICKS_TOP) ticks = TICKS_TOP;
    return ticks[27:0];
  endfunction

  function automatic cbb_out_t step_blocker(cbb_in_t ev);
    cbb_out_t res;
    bit blocked_now;
    blocked_now = counting_q || offline_q;
    res = '0;
    case (ev.action)
      ACT_TICK: begin
        if (counting_q) begin
          if (remain_q != 0) remain_q--;
          if (remain_q == 0) counting_q = 0;
        end
      end
      ACT_SUCCESS: begin
        if (blocked_now) res.ignored = 1'b1;
        else fails_q = '0;
      end
      ACT_FAILURE: begin
        if (blocked_now) begin
          res.ignored = 1'b1;
        end else begin
          if (fails_q != COUNT_TOP) fails_q++;
          res.backoff_loaded = backoff_ticks(fails_q, ev.random_sample);
          remain_q = res.backoff_loaded;
          counting_q = 1;
        end
      end
      ACT_OFFLINE: begin
        counting_q = 0;
        remain_q = '0;
        offline_q = 1;
      end
      ACT_ONLINE: begin
        counting_q = 0;
        remain_q = '0;
        offline_q = 0;
        fails_q = '0;
      end
      default: ;
    endcase
    res.blocked = counting_q || offline_q;
    res.fail_count = fails_q;
    return res;
  endfunction

  function automatic cbb_in_t make_event(logic [2:0] act, logic [15:0] smp);
    cbb_in_t ev;
    ev.action = act;
    ev.random_sample = smp;
    return ev;
  endfunction

  function automatic cbb_out_t outcome(bit blk, logic [15:0] cnt, bit ign, logic [27:0] ld);
    cbb_out_t res;
    res.blocked = blk;
    res.fail_count = cnt;
    res.ignored = ign;
    res.backoff_loaded = ld;
    return res;
  endfunction

  function automatic plan_row_t event_row(logic [2:0] act, logic [15:0] smp, bit typed = 0,
                                          cbb_out_t want = '0);
    plan_row_t r;
    r.is_cfg = 0;
    r.base = '0;
    r.ev = make_event(act, smp);
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic plan_row_t base_row(logic [BASE_W-1:0] base);
    plan_row_t r;
    r = event_row(ACT_TICK, JITTER_NONE);
    r.is_cfg = 1;
    r.base = base;
    return r;
  endfunction

  function automatic cbb_in_t random_event(bit restless);
    int unsigned r, s;
    logic [2:0] act;
    logic [15:0] smp;
    r = $urandom_range(99);
    if (restless) begin
      if (r < 25)      act = ACT_TICK;
      else if (r < 55) act = ACT_FAILURE;
      else if (r < 65) act = ACT_SUCCESS;
      else if (r < 72) act = ACT_OFFLINE;
      else if (r < 95) act = ACT_ONLINE;
      else             act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    end else begin
      if (r < 50)      act = ACT_TICK;
      else if (r < 70) act = ACT_FAILURE;
      else if (r < 80) act = ACT_SUCCESS;
      else if (r < 86) act = ACT_OFFLINE;
      else if (r < 95) act = ACT_ONLINE;
      else             act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    end
    s = $urandom_range(9);
    case (s)
      0:       smp = JITTER_LOW;
      1:       smp = JITTER_HIGH;
      2:       smp = JITTER_NONE;
      default: smp = 16'($urandom_range(65535));
    endcase
    return make_event(act, smp);
  endfunction

  // offer one event, hold it until the transfer, then record what it should produce
  task automatic push_event(cbb_in_t ev, bit typed = 0, cbb_out_t want = '0);
    cbb_out_t predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = step_blocker(ev);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_base(logic [BASE_W-1:0] base);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= base;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    base_ticks_q = base;
  endtask

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 17);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data_o);
        mismatches++;
      end else begin
        head = pending_results.pop_front();
        if (out_data_o.blocked !== head.blocked) begin
          $error("blocked: expected %0d, got %0d", head.blocked, out_data_o.blocked);
          mismatches++;
        end
        if (out_data_o.fail_count !== head.fail_count) begin
          $error("fail_count: expected %0d, got %0d", head.fail_count, out_data_o.fail_count);
          mismatches++;
        end
        if (out_data_o.ignored !== head.ignored) begin
          $error("ignored: expected %0d, got %0d", head.ignored, out_data_o.ignored);
          mismatches++;
        end
        if (out_data_o.backoff_loaded !== head.backoff_loaded) begin
          $error("backoff_loaded: expected %0d, got %0d", head.backoff_loaded,
                 out_data_o.backoff_loaded);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    plan_row_t         plan [$];
    logic [BASE_W-1:0] phase_base [9];
    bit                restless;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    mismatches   = 0;
    cycle_count  = 0;
    calm         = 0;
    hold_req     = 0;
    base_ticks_q = BASE_TICKS_RESET;
    fails_q      = '0;
    remain_q     = '0;
    counting_q   = 0;
    offline_q    = 0;

    // base 1000 after reset
    plan.push_back(event_row(ACT_TICK, JITTER_NONE, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_SUCCESS, JITTER_NONE, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_SPARE_LO, JITTER_HIGH, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_SPARE_MID, 16'h5555, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_SPARE_HI, JITTER_LOW, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_FAILURE, JITTER_NONE, 1, outcome(1, 1, 0, 1602)));
    plan.push_back(event_row(ACT_SUCCESS, JITTER_NONE, 1, outcome(1, 1, 1, 0)));
    plan.push_back(event_row(ACT_FAILURE, 16'hAAAA, 1, outcome(1, 1, 1, 0)));
    plan.push_back(event_row(ACT_OFFLINE, JITTER_NONE, 1, outcome(1, 1, 0, 0)));
    plan.push_back(event_row(ACT_OFFLINE, JITTER_NONE, 1, outcome(1, 1, 0, 0)));
    plan.push_back(event_row(ACT_TICK, JITTER_NONE, 1, outcome(1, 1, 0, 0)));
    plan.push_back(event_row(ACT_ONLINE, JITTER_NONE, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_FAILURE, JITTER_LOW));
    plan.push_back(event_row(ACT_ONLINE, JITTER_NONE));
    plan.push_back(event_row(ACT_FAILURE, JITTER_HIGH));
    // base of one: two ticks end the countdown
    plan.push_back(base_row(20'd1));
    plan.push_back(event_row(ACT_ONLINE, JITTER_NONE, 1, outcome(0, 0, 0, 0)));
    plan.push_back(event_row(ACT_FAILURE, JITTER_NONE, 1, outcome(1, 1, 0, 2)));
    plan.push_back(event_row(ACT_TICK, JITTER_NONE, 1, outcome(1, 1, 0, 0)));
    plan.push_back(event_row(ACT_TICK, JITTER_NONE, 1, outcome(0, 1, 0, 0)));
    plan.push_back(event_row(ACT_TICK, JITTER_NONE, 1, outcome(0, 1, 0, 0)));
    plan.push_back(event_row(ACT_FAILURE, JITTER_LOW));
    plan.push_back(event_row(ACT_OFFLINE, JITTER_NONE, 1, outcome(1, 2, 0, 0)));
    plan.push_back(event_row(ACT_ONLINE, JITTER_NONE, 1, outcome(0, 0, 0, 0)));
    // zero base clamps to a single tick
    plan.push_back(base_row(20'd0));
    plan.push_back(event_row(ACT_FAILURE, JITTER_NONE, 1, outcome(1, 1, 0, 1)));
    plan.push_back(event_row(ACT_TICK, JITTER_NONE, 1, outcome(0, 1, 0, 0)));
    plan.push_back(base_row({BASE_W{1'b1}}));
    plan.push_back(event_row(ACT_FAILURE, JITTER_HIGH));

    phase_base = '{20'd1, 20'd2, 20'd3, 20'($urandom_range(15, 1)), 20'd1,
                   20'd1000, {BASE_W{1'b1}}, 20'($urandom_range(1048575)), 20'd0};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].is_cfg) set_base(plan[k].base);
      else push_event(plan[k].ev, plan[k].typed, plan[k].want);
    end

    foreach (phase_base[p]) begin
      set_base(phase_base[p]);
      restless = (phase_base[p] > 20);
      calm = (p == 4);
      if (p == 2) hold_req = 1;
      for (int n = 0; n < PHASE_ITEMS; n++) push_event(random_event(restless));
    end
    calm = 0;

    // run the count well past the exponent limit: with zero base every failure
    // clears in one tick
    set_base(20'd0);
    calm = 1;
    push_event(make_event(ACT_ONLINE, JITTER_NONE));
    for (int n = 0; n < RUN_FAILURES; n++) begin
      push_event(make_event(ACT_FAILURE, 16'($urandom_range(65535))));
      push_event(make_event(ACT_TICK, 16'($urandom_range(65535))));
    end
    calm = 0;

    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
